// ----- hw/rtl/ptc_pkg.sv -----
package ptc_pkg;

    localparam int PIX_W      = 16;
    localparam int CEN_W      = 12;
    localparam int PER_W      = 16;
    localparam int COEF_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int CMD_W      = 40;
    localparam int EPIX_W     = 18;
    localparam int OP_W       = 25;
    localparam int PROD_W     = 50;
    localparam int ACC_W      = 60;
    localparam int D_W        = 42;
    localparam int TICK_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 3'd6;

    // multiplier operand selection
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE = 3'd0;
    localparam t_mul_sel MUL_ERR  = 3'd1;
    localparam t_mul_sel MUL_ZLO  = 3'd2;
    localparam t_mul_sel MUL_ZHI  = 3'd3;
    localparam t_mul_sel MUL_GLO  = 3'd4;
    localparam t_mul_sel MUL_GHI  = 3'd5;

    // accumulator operation
    typedef logic [1:0] t_acc_op;
    localparam t_acc_op ACC_HOLD  = 2'd0;
    localparam t_acc_op ACC_LOAD  = 2'd1;
    localparam t_acc_op ACC_ADD_Z = 2'd2;
    localparam t_acc_op ACC_ADD_G = 2'd3;

    typedef struct packed {
        logic [CEN_W-1:0]          center_x;
        logic [CEN_W-1:0]          center_y;
        logic [PER_W-1:0]          period;
        logic signed [COEF_W-1:0]  gain_x;
        logic signed [COEF_W-1:0]  gain_y;
        logic [COEF_W-1:0]         zero_coef;
        logic [SCALE_W-1:0]        pixel_scale;
    } t_cfg;

    typedef struct packed {
        logic     cap;
        t_mul_sel mul_sel;
        logic     axis;
        logic     err_wr;
        t_acc_op  acc_op;
        logic     d_wr;
        logic     u_wr;
        logic     commit;
        logic     out_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic upd;
        logic out_busy;
    } t_dp_stat;

endpackage

// ----- hw/rtl/ptc_ctrl.sv -----
module ptc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ptc_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output ptc_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_E0   = 4'd1;
    localparam logic [3:0] S_W0   = 4'd2;
    localparam logic [3:0] S_E1   = 4'd3;
    localparam logic [3:0] S_W1   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_ZL   = 4'd6;
    localparam logic [3:0] S_ZH   = 4'd7;
    localparam logic [3:0] S_T    = 4'd8;
    localparam logic [3:0] S_D    = 4'd9;
    localparam logic [3:0] S_GL   = 4'd10;
    localparam logic [3:0] S_GH   = 4'd11;
    localparam logic [3:0] S_DL   = 4'd12;
    localparam logic [3:0] S_U    = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_axis        = r_axis;
        o_cmd         = '0;
        o_cmd.mul_sel = ptc_pkg::MUL_NONE;
        o_cmd.acc_op  = ptc_pkg::ACC_HOLD;
        o_cmd.axis    = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_E0;
                end
            end
            S_E0: begin
                o_cmd.axis    = 1'b0;
                o_cmd.mul_sel = ptc_pkg::MUL_ERR;
                n_state       = S_W0;
            end
            S_W0: begin
                o_cmd.axis   = 1'b0;
                o_cmd.err_wr = 1'b1;
                n_state      = S_E1;
            end
            S_E1: begin
                o_cmd.axis    = 1'b1;
                o_cmd.mul_sel = ptc_pkg::MUL_ERR;
                n_state       = S_W1;
            end
            S_W1: begin
                o_cmd.axis   = 1'b1;
                o_cmd.err_wr = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                n_axis = 1'b0;
                if (i_stat.upd) begin
                    n_state = S_ZL;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ZL: begin
                o_cmd.mul_sel = ptc_pkg::MUL_ZLO;
                n_state       = S_ZH;
            end
            S_ZH: begin
                o_cmd.acc_op  = ptc_pkg::ACC_LOAD;
                o_cmd.mul_sel = ptc_pkg::MUL_ZHI;
                n_state       = S_T;
            end
            S_T: begin
                o_cmd.acc_op = ptc_pkg::ACC_ADD_Z;
                n_state      = S_D;
            end
            S_D: begin
                o_cmd.d_wr = 1'b1;
                n_state    = S_GL;
            end
            S_GL: begin
                o_cmd.mul_sel = ptc_pkg::MUL_GLO;
                n_state       = S_GH;
            end
            S_GH: begin
                o_cmd.acc_op  = ptc_pkg::ACC_LOAD;
                o_cmd.mul_sel = ptc_pkg::MUL_GHI;
                n_state       = S_DL;
            end
            S_DL: begin
                o_cmd.acc_op = ptc_pkg::ACC_ADD_G;
                n_state      = S_U;
            end
            S_U: begin
                o_cmd.u_wr = 1'b1;
                if (r_axis) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_ZL;
                end
            end
            S_OUT: begin
                // hold until the previous result has left
                if (!i_stat.out_busy) begin
                    o_cmd.out_wr = 1'b1;
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ptc_dp.sv -----
module ptc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptc_pkg::t_cfg                        i_cfg,
    input  ptc_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [ptc_pkg::PIX_W-1:0]     i_pixel_col,
    input  logic signed [ptc_pkg::PIX_W-1:0]     i_pixel_row,
    input  logic                                 i_out_ready,
    output ptc_pkg::t_dp_stat                    o_stat,
    output logic                                 o_out_valid,
    output logic signed [ptc_pkg::CMD_W-1:0]     o_yaw_cmd,
    output logic signed [ptc_pkg::CMD_W-1:0]     o_pitch_cmd
);

    localparam int EW = ptc_pkg::EPIX_W;
    localparam int CW = ptc_pkg::CMD_W;
    localparam int PW = ptc_pkg::PROD_W;
    localparam int AW = ptc_pkg::ACC_W;
    localparam int DW = ptc_pkg::D_W;
    localparam int TW = ptc_pkg::TICK_W;

    function automatic logic signed [CW-1:0] sat40(input logic signed [PW-1:0] v);
        if (v[PW-1:CW-1] != {(PW-CW+1){v[PW-1]}}) begin
            return v[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return v[CW-1:0];
    endfunction

    logic signed [EW-1:0] r_epix [2];
    logic                 r_hold [2];
    logic signed [CW-1:0] r_errn [2];
    logic signed [CW-1:0] r_prev [2];
    logic signed [CW-1:0] r_drive [2];
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [DW-1:0] r_d;
    logic [TW-1:0]        r_tick;
    logic                 r_out_valid;
    logic signed [CW-1:0] r_yaw, r_pitch;

    logic signed [EW-1:0]       w_cen_x, w_cen_y, w_e_col, w_e_row;
    logic signed [ptc_pkg::OP_W-1:0] w_op_a, w_op_b;
    logic signed [PW-1:0]       w_prod;
    logic signed [AW-1:0]       w_prod_ext;
    logic signed [CW-1:0]       w_err_sel, w_prev_sel, w_drive_sel;
    logic signed [ptc_pkg::COEF_W-1:0] w_gain_sel;
    logic signed [PW-1:0]       w_sum;

    assign w_cen_x = $signed({{(EW-ptc_pkg::CEN_W){1'b0}}, i_cfg.center_x});
    assign w_cen_y = $signed({{(EW-ptc_pkg::CEN_W){1'b0}}, i_cfg.center_y});
    assign w_e_col = w_cen_x - {{(EW-ptc_pkg::PIX_W){i_pixel_col[ptc_pkg::PIX_W-1]}}, i_pixel_col};
    assign w_e_row = w_cen_y - {{(EW-ptc_pkg::PIX_W){i_pixel_row[ptc_pkg::PIX_W-1]}}, i_pixel_row};

    assign w_err_sel   = r_errn[i_cmd.axis];
    assign w_prev_sel  = r_prev[i_cmd.axis];
    assign w_drive_sel = r_drive[i_cmd.axis];
    assign w_gain_sel  = i_cmd.axis ? i_cfg.gain_y : i_cfg.gain_x;

    always_comb begin
        case (i_cmd.mul_sel)
            ptc_pkg::MUL_ERR: begin
                w_op_a = {{7{r_epix[i_cmd.axis][EW-1]}}, r_epix[i_cmd.axis]};
                w_op_b = {1'b0, i_cfg.pixel_scale};
            end
            ptc_pkg::MUL_ZLO: begin
                w_op_a = {5'b0, w_err_sel[19:0]};
                w_op_b = {9'b0, i_cfg.zero_coef};
            end
            ptc_pkg::MUL_ZHI: begin
                w_op_a = {{5{w_err_sel[CW-1]}}, w_err_sel[CW-1:20]};
                w_op_b = {9'b0, i_cfg.zero_coef};
            end
            ptc_pkg::MUL_GLO: begin
                w_op_a = {4'b0, r_d[20:0]};
                w_op_b = {{9{w_gain_sel[15]}}, w_gain_sel};
            end
            ptc_pkg::MUL_GHI: begin
                w_op_a = {{4{r_d[DW-1]}}, r_d[DW-1:21]};
                w_op_b = {{9{w_gain_sel[15]}}, w_gain_sel};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod     = w_op_a * w_op_b;
    assign w_prod_ext = {{(AW-PW){r_prod[PW-1]}}, r_prod};
    // drive plus delta, delta = acc >>> 12
    assign w_sum = {{(PW-CW){w_drive_sel[CW-1]}}, w_drive_sel}
                 + {{(PW-(AW-12)){r_acc[AW-1]}}, r_acc[AW-1:12]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_epix[0] <= w_e_col;
            r_epix[1] <= w_e_row;
            r_hold[0] <= (w_e_col > w_cen_x) || (w_e_col < -w_cen_x);
            r_hold[1] <= (w_e_row > w_cen_y) || (w_e_row < -w_cen_y);
        end
        if (i_cmd.mul_sel != ptc_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.err_wr) begin
            r_errn[i_cmd.axis] <= sat40(r_prod);
        end
        case (i_cmd.acc_op)
            ptc_pkg::ACC_LOAD:  r_acc <= w_prod_ext;
            ptc_pkg::ACC_ADD_Z: r_acc <= r_acc + (w_prod_ext <<< 20) + AW'(16384);
            ptc_pkg::ACC_ADD_G: r_acc <= r_acc + (w_prod_ext <<< 21) + AW'(2048);
            default:            r_acc <= r_acc;
        endcase
        if (i_cmd.d_wr) begin
            // d = prev - round(err * zero / 2^15)
            r_d <= {{(DW-CW){w_prev_sel[CW-1]}}, w_prev_sel} - r_acc[DW+14:15];
        end
        if (i_cmd.out_wr) begin
            r_yaw   <= r_drive[0];
            r_pitch <= r_drive[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0]   <= '0;
            r_prev[1]   <= '0;
            r_drive[0]  <= '0;
            r_drive[1]  <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.u_wr && !r_hold[i_cmd.axis]) begin
                r_drive[i_cmd.axis] <= sat40(w_sum);
            end
            if (i_cmd.commit) begin
                r_prev[0] <= r_errn[0];
                r_prev[1] <= r_errn[1];
                if (o_stat.upd) begin
                    r_tick <= TW'(1);
                end else if (r_tick != {TW{1'b1}}) begin
                    r_tick <= r_tick + TW'(1);
                end
            end
            if (i_cmd.out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.upd      = r_tick > {{(TW-ptc_pkg::PER_W){1'b0}}, i_cfg.period};
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_yaw_cmd       = r_yaw;
    assign o_pitch_cmd     = r_pitch;

endmodule

// ----- hw/rtl/pixel_tracking_compensator_unit.sv -----
// Steps: every tick computes the two scaled errors and then checks for an update; a tick
// that does not update returns to idle. An update tick then runs each axis in turn on one
// shared 25x25 multiplier and loads the result (held until taken; a result still waiting
// stalls the load) before it goes back to idle.
// Input is ready only in idle, so no new tick is taken before the last one is done.
// Reset (synchronous, active low) clears counter, last errors, drives; restores defaults.
module pixel_tracking_compensator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // pixel_col [15:0], pixel_row [31:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // yaw_cmd [39:0], pitch_cmd [79:40]
    input  logic        i_cfg_wr_en,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ptc_pkg::t_cfg     r_cfg;
    ptc_pkg::t_dp_cmd  w_cmd;
    ptc_pkg::t_dp_stat w_stat;
    logic signed [ptc_pkg::CMD_W-1:0] w_yaw, w_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= 12'd400;
            r_cfg.center_y    <= 12'd300;
            r_cfg.period      <= 16'd10;
            r_cfg.gain_x      <= 16'sd3277;
            r_cfg.gain_y      <= -16'sd410;
            r_cfg.zero_coef   <= 16'd31130;
            r_cfg.pixel_scale <= 24'd45214;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                ptc_pkg::REG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[11:0];
                ptc_pkg::REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[11:0];
                ptc_pkg::REG_PERIOD:      r_cfg.period      <= i_cfg_data[15:0];
                ptc_pkg::REG_GAIN_X:      r_cfg.gain_x      <= i_cfg_data[15:0];
                ptc_pkg::REG_GAIN_Y:      r_cfg.gain_y      <= i_cfg_data[15:0];
                ptc_pkg::REG_ZERO_COEF:   r_cfg.zero_coef   <= i_cfg_data[15:0];
                ptc_pkg::REG_PIXEL_SCALE: r_cfg.pixel_scale <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    ptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    ptc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_pixel_col ($signed(i_s_axis_tdata[15:0])),
        .i_pixel_row ($signed(i_s_axis_tdata[31:16])),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_yaw_cmd   (w_yaw),
        .o_pitch_cmd (w_pitch)
    );

    assign o_m_axis_tdata = {w_pitch, w_yaw};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a tick is in flight");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_wr |=> o_m_axis_tvalid)
        else $error("result written but not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.out_wr && o_m_axis_tvalid && !i_m_axis_tready))
        else $error("pending result overwritten");

endmodule

// ----- tb/sv/ptc_command_checker.sv -----
`timescale 1ns / 100ps

module ptc_command_checker
    import ptc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  o_s_axis_tready,
    input  logic [31:0]           i_s_axis_tdata,   // pixel_col [15:0], pixel_row [31:16]
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [79:0]           o_m_axis_tdata,   // yaw_cmd [39:0], pitch_cmd [79:40]
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_cmds_pending,
    output int                    o_cmds_checked
);

    localparam longint CMD_MAX = 64'sd549755813887;
    localparam longint CMD_MIN = -64'sd549755813888;

    typedef struct {
        logic signed [CMD_W-1:0] yaw;
        logic signed [CMD_W-1:0] pitch;
    } cmd_pair_t;

    t_cfg                cfg;
    logic [TICK_W-1:0]   tick_count;
    longint              prev_err_col;
    longint              prev_err_row;
    longint              drive_col;
    longint              drive_row;
    cmd_pair_t           cmd_queue[$];
    int                  fail_total = 0;
    int                  checked_total = 0;

    initial begin
        o_fail_count   = 0;
        o_cmds_pending = 0;
        o_cmds_checked = 0;
    end

    function automatic longint clamp_cmd(longint v);
        if (v > CMD_MAX) return CMD_MAX;
        if (v < CMD_MIN) return CMD_MIN;
        return v;
    endfunction

    function automatic longint angle_error(longint e_pix);
        return clamp_cmd(e_pix * longint'(cfg.pixel_scale));
    endfunction

    // one axis of the incremental compensator; hold the drive when the target is off range
    function automatic longint next_drive(longint e_pix, longint err, longint center,
                                          longint prev, longint drive, longint gain);
        longint mag;
        longint weighted;
        longint diff;
        longint delta;
        mag = (e_pix < 0) ? -e_pix : e_pix;
        if (mag > center) return drive;
        weighted = (err * longint'(cfg.zero_coef) + 64'sd16384) >>> 15;
        diff     = prev - weighted;
        delta    = (gain * diff + 64'sd2048) >>> 12;
        return clamp_cmd(drive + delta);
    endfunction

    task automatic restore_defaults();
        cfg.center_x    = 12'd400;
        cfg.center_y    = 12'd300;
        cfg.period      = 16'd10;
        cfg.gain_x      = 16'sd3277;
        cfg.gain_y      = -16'sd410;
        cfg.zero_coef   = 16'd31130;
        cfg.pixel_scale = 24'd45214;
        tick_count      = '0;
        prev_err_col    = 0;
        prev_err_row    = 0;
        drive_col       = 0;
        drive_row       = 0;
        cmd_queue.delete();
    endtask

    task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER_X:    cfg.center_x    = data[CEN_W-1:0];
            REG_CENTER_Y:    cfg.center_y    = data[CEN_W-1:0];
            REG_PERIOD:      cfg.period      = data[PER_W-1:0];
            REG_GAIN_X:      cfg.gain_x      = data[COEF_W-1:0];
            REG_GAIN_Y:      cfg.gain_y      = data[COEF_W-1:0];
            REG_ZERO_COEF:   cfg.zero_coef   = data[COEF_W-1:0];
            REG_PIXEL_SCALE: cfg.pixel_scale = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic take_tick(logic [31:0] data);
        logic signed [PIX_W-1:0] col;
        logic signed [PIX_W-1:0] row;
        longint                  e_col;
        longint                  e_row;
        longint                  err_col;
        longint                  err_row;
        cmd_pair_t               cmd;
        col     = data[15:0];
        row     = data[31:16];
        e_col   = longint'(cfg.center_x) - longint'(col);
        e_row   = longint'(cfg.center_y) - longint'(row);
        err_col = angle_error(e_col);
        err_row = angle_error(e_row);
        if (tick_count > cfg.period) begin
            drive_col = next_drive(e_col, err_col, cfg.center_x, prev_err_col, drive_col,
                                   cfg.gain_x);
            drive_row = next_drive(e_row, err_row, cfg.center_y, prev_err_row, drive_row,
                                   cfg.gain_y);
            cmd.yaw   = drive_col[CMD_W-1:0];
            cmd.pitch = drive_row[CMD_W-1:0];
            cmd_queue.push_back(cmd);
            tick_count = 1;
        end else if (tick_count != '1) begin
            tick_count = tick_count + 1'b1;
        end
        prev_err_col = err_col;
        prev_err_row = err_row;
    endtask

    task automatic check_cmd(logic [79:0] data);
        logic signed [CMD_W-1:0] yaw;
        logic signed [CMD_W-1:0] pitch;
        cmd_pair_t               want;
        yaw   = data[39:0];
        pitch = data[79:40];
        if (cmd_queue.size() == 0) begin
            $error("command with none pending: yaw_cmd %0d pitch_cmd %0d", yaw, pitch);
            fail_total++;
        end else begin
            want = cmd_queue.pop_front();
            checked_total++;
            if (yaw !== want.yaw) begin
                $error("yaw_cmd mismatch: expected %0d, actual %0d", want.yaw, yaw);
                fail_total++;
            end
            if (pitch !== want.pitch) begin
                $error("pitch_cmd mismatch: expected %0d, actual %0d", want.pitch, pitch);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_wr_en) apply_reg_write(i_cfg_idx, i_cfg_data);
            if (o_m_axis_tvalid && i_m_axis_tready) check_cmd(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready) take_tick(i_s_axis_tdata);
        end
        // publish after the edge so the stimulus side sees settled counts
        o_fail_count   <= fail_total;
        o_cmds_pending <= cmd_queue.size();
        o_cmds_checked <= checked_total;
    end

endmodule

// ----- tb/sv/pixel_tracking_compensator_unit_tb.sv -----
`timescale 1ns / 100ps

module pixel_tracking_compensator_unit_tb;

    import ptc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_TICKS  = 200;
    localparam int SETTINGS_RAND = 5;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [31:0]           i_s_axis_tdata;   // pixel_col [15:0], pixel_row [31:16]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [79:0]           o_m_axis_tdata;   // yaw_cmd [39:0], pitch_cmd [79:40]
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int cmds_pending;
    int cmds_checked;
    int cycle_count   = 0;
    int ticks_sent    = 0;
    int settings_used = 1;
    int cur_center_x  = 400;
    int cur_center_y  = 300;
    bit idle_on       = 1'b1;

    shortint warm_col[12] = '{0, 32767, -32768, 400, 800, 801, -1, 1, 0, 4095, 10, 399};
    shortint warm_row[12] = '{0, 32767, -32768, 300, 600, 601, -1, 0, 1, -4095, 20, 299};
    shortint wide_col[8]  = '{-32768, 0, 4095, 32767, 2000, 4095, 0, -1};
    shortint wide_row[8]  = '{32767, 0, 0, -32768, 0, 1, 0, 0};

    always #5 i_clk = ~i_clk;

    pixel_tracking_compensator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    ptc_command_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_cmds_pending  (cmds_pending),
        .o_cmds_checked  (cmds_checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // command sink: stall in short random bursts
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // leave tvalid high on return; the caller drops it with stop_ticks
    task automatic push_tick(shortint col, shortint row);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {row, col};
        do @(posedge i_clk); while (!o_s_axis_tready);
        ticks_sent++;
    endtask

    task automatic stop_ticks();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // wait for every pending command, then let a non-updating tick finish
    task automatic settle();
        @(posedge i_clk);
        while (cmds_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_CENTER_X) cur_center_x = data[CEN_W-1:0];
        if (idx == REG_CENTER_Y) cur_center_y = data[CEN_W-1:0];
    endtask

    // mostly near the center so both update and hold paths are hit
    function automatic shortint pick_pixel(int center);
        if ($urandom_range(0, 3) == 0) return shortint'($urandom);
        return shortint'(center + int'($urandom_range(0, 2 * center + 40)) - center - 20);
    endfunction

    task automatic program_setting(int phase);
        logic [CFG_DATA_W-1:0] cx;
        logic [CFG_DATA_W-1:0] cy;
        logic [CFG_DATA_W-1:0] per;
        logic [CFG_DATA_W-1:0] gx;
        logic [CFG_DATA_W-1:0] gy;
        logic [CFG_DATA_W-1:0] zc;
        logic [CFG_DATA_W-1:0] sc;
        // upper bits above each register width are random and must be dropped
        cx  = 24'($urandom);
        cy  = 24'($urandom);
        per = {8'($urandom), 16'($urandom_range(0, 6))};
        gx  = 24'($urandom);
        gy  = 24'($urandom);
        zc  = 24'($urandom);
        sc  = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 65535));
        case (phase)
            1: begin
                cx  = 24'h000000;
                cy  = 24'h000FFF;
                per = 24'h000000;
                gx  = 24'h008000;
                gy  = 24'h007FFF;
                zc  = 24'h000000;
                sc  = 24'h000001;
            end
            2: per = 24'($urandom_range(8, 20));
            3: sc = 24'h000000;
            default: ;
        endcase
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_PERIOD, per);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_ZERO_COEF, zc);
        write_reg(REG_PIXEL_SCALE, sc);
        settings_used++;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: zero error, exact-center and off-range pixels;
        // only the twelfth transfer exceeds the period
        for (int k = 0; k < 12; k++) push_tick(warm_col[k], warm_row[k]);
        stop_ticks();
        settle();

        // extreme registers, update on every transfer, saturated errors and drives
        write_reg(REG_CENTER_X, 24'h5A5FFF);
        write_reg(REG_CENTER_Y, 24'hA5A000);
        write_reg(REG_PERIOD, 24'hC30000);
        write_reg(REG_GAIN_X, 24'h3C7FFF);
        write_reg(REG_GAIN_Y, 24'hC38000);
        write_reg(REG_ZERO_COEF, 24'h00FFFF);
        write_reg(REG_PIXEL_SCALE, 24'hFFFFFF);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        settings_used++;
        for (int k = 0; k < 8; k++) push_tick(wide_col[k], wide_row[k]);
        stop_ticks();
        settle();

        // longest period: these transfers only advance the counter
        write_reg(REG_PERIOD, 24'h00FFFF);
        for (int k = 0; k < 3; k++) push_tick(pick_pixel(cur_center_x), pick_pixel(cur_center_y));
        stop_ticks();
        settle();

        for (int p = 0; p < SETTINGS_RAND; p++) begin
            idle_on = (p != SETTINGS_RAND - 1);
            program_setting(p);
            for (int n = 0; n < RANDOM_TICKS; n++) begin
                if (p == 2 && n == RANDOM_TICKS / 2) begin
                    stop_ticks();
                    settle();
                end
                push_tick(pick_pixel(cur_center_x), pick_pixel(cur_center_y));
            end
            stop_ticks();
            settle();
        end

        $display("Run covered %0d sensor ticks and %0d commands over %0d register settings,",
                 ticks_sent, cmds_checked, settings_used);
        $display("including period zero and maximum, off-range holds and saturated drives.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
